// ===== rtl/cbf_pkg.sv =====
package cbf_pkg;

    localparam int COORD_W       = 24;
    localparam int TOL_W         = 16;
    localparam int MAX_POINTS    = 64;
    localparam int MAX_LEVEL_DEF = 5;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd64;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } cbf_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } cbf_out_t;

endpackage

// ===== rtl/cubic_bezier_flattener.sv =====
// Channel   | Ports                      | Carries
// ----------+----------------------------+----------------------------------------
// segment   | s_valid s_ready s_data     | start, two control points, end (Q16.8)
// vertex    | m_valid m_ready m_data     | polyline vertex, last_point on the final
// tolerance | cfg_wr_en cfg_wr_data      | flatness tolerance, unsigned Q8.8
//
// Each flatness test runs through one shared signed multiplier
// (cross products, chord length, then d^2 and s*tol in halves). A piece past the
// level limit or with a full stack skips the test. A halving passes through the
// decision state; an emitted vertex passes through the decision state and, unless
// it is the last, the pop state for the pending-stack memory read. Full depth at
// five levels takes 63 halvings and gives 64 vertices at the limit.
// Reset is synchronous, active low, and clears control state and the point registers; the
// pending stack needs no clearing pass. A stalled vertex holds the sequencer
// at its next emit; a new segment is taken once the last vertex is loaded.
module cubic_bezier_flattener #(
    parameter int MAX_LEVEL = cbf_pkg::MAX_LEVEL_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cbf_pkg::cbf_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cbf_pkg::cbf_out_t             m_data,
    input  logic                          cfg_wr_en,
    input  logic [cbf_pkg::TOL_W-1:0]     cfg_wr_data
);
    import cbf_pkg::*;

    localparam int C    = COORD_W;
    localparam int H    = C + 2;            // half width of d and s
    localparam int MW   = H + 1;            // signed multiplier operand
    localparam int PW   = 2 * MW;
    localparam int DW   = 2 * H;
    localparam int QW   = 4 * H;
    localparam int RW   = 2 * H + TOL_W;
    localparam int SD   = MAX_LEVEL + 1;    // stack depth
    localparam int AW   = (SD > 1) ? $clog2(SD) : 1;
    localparam int TW   = $clog2(SD + 1);
    localparam int LW   = $clog2(MAX_LEVEL + 2);
    localparam int NW   = $clog2(MAX_POINTS);
    localparam logic [3:0] STEP_LAST = 4'd12;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TEST   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_POP    = 3'd3;

    typedef struct packed {
        logic signed [C-1:0] x;
        logic signed [C-1:0] y;
    } pt_t;

    typedef struct packed {
        pt_t           c1;
        pt_t           c2;
        pt_t           e;
        logic [LW-1:0] level;
    } ent_t;

    function automatic logic signed [C-1:0] mid1(logic signed [C-1:0] a,
                                                 logic signed [C-1:0] b);
        logic signed [C:0] s;
        s = {a[C-1], a} + {b[C-1], b};
        return s[C:1];
    endfunction

    function automatic pt_t midpt(pt_t a, pt_t b);
        pt_t r;
        r.x = mid1(a.x, b.x);
        r.y = mid1(a.y, b.y);
        return r;
    endfunction

    function automatic logic signed [MW-1:0] dif(logic signed [C-1:0] a,
                                                 logic signed [C-1:0] b);
        return {{(MW-C){a[C-1]}}, a} - {{(MW-C){b[C-1]}}, b};
    endfunction

    logic [2:0]          state_reg;
    logic [3:0]          step_reg;
    pt_t                 p0_reg, p1_reg, p2_reg, p3_reg, seg_end_reg;
    logic [LW-1:0]       level_reg;
    logic [TW-1:0]       top_reg;
    logic [NW-1:0]       n_reg;
    logic                final_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic signed [PW-1:0] prod_reg, t_reg, cr_reg;
    logic [DW-1:0]       d_reg, s_reg;
    logic [QW-1:0]       q_reg;
    logic [RW-1:0]       r_reg;
    cbf_out_t            out_reg;
    logic                m_valid_reg;

    ent_t                mem [SD];
    ent_t                rd_data_reg;

    logic signed [MW-1:0] dx, dy, e1x, e1y, e2x, e2y, dl, dh, sl, sh, tl;
    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] prod_c;
    logic [PW-1:0]        prod_u;
    logic                 cr_neg, lim, flat_c, slot_free, emit;
    pt_t                  pa, pb, pc, pab, pbc, pm;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [TW-1:0]        top_dec;

    assign dx  = dif(p3_reg.x, p0_reg.x);
    assign dy  = dif(p3_reg.y, p0_reg.y);
    assign e1x = dif(p1_reg.x, p3_reg.x);
    assign e1y = dif(p1_reg.y, p3_reg.y);
    assign e2x = dif(p2_reg.x, p3_reg.x);
    assign e2y = dif(p2_reg.y, p3_reg.y);
    assign dl  = {1'b0, d_reg[H-1:0]};
    assign dh  = {1'b0, d_reg[DW-1:H]};
    assign sl  = {1'b0, s_reg[H-1:0]};
    assign sh  = {1'b0, s_reg[DW-1:H]};
    assign tl  = {{(MW-TOL_W){1'b0}}, tol_reg};

    // Operand schedule of the shared multiplier
    always_comb begin
        case (step_reg)
            4'd0:    begin ma = e1x; mb = dy; end
            4'd1:    begin ma = e1y; mb = dx; end
            4'd2:    begin ma = e2x; mb = dy; end
            4'd3:    begin ma = e2y; mb = dx; end
            4'd4:    begin ma = dx;  mb = dx; end
            4'd5:    begin ma = dy;  mb = dy; end
            4'd6:    begin ma = dl;  mb = dl; end
            4'd7:    begin ma = dh;  mb = dl; end
            4'd8:    begin ma = dh;  mb = dh; end
            4'd9:    begin ma = sl;  mb = tl; end
            4'd10:   begin ma = sh;  mb = tl; end
            default: begin ma = '0;  mb = '0; end
        endcase
    end

    assign prod_c    = ma * mb;
    assign prod_u    = prod_reg;
    assign cr_neg    = cr_reg[PW-1];
    assign flat_c    = q_reg < (QW'(r_reg) << 8);
    assign lim       = (level_reg > LW'(MAX_LEVEL)) || (top_reg >= TW'(SD));
    assign slot_free = !m_valid_reg || m_ready;
    assign emit      = (state_reg == ST_DECIDE) && final_reg && slot_free;

    assign pa  = midpt(p0_reg, p1_reg);
    assign pb  = midpt(p1_reg, p2_reg);
    assign pc  = midpt(p2_reg, p3_reg);
    assign pab = midpt(pa, pb);
    assign pbc = midpt(pb, pc);
    assign pm  = midpt(pab, pbc);

    assign top_dec = top_reg - TW'(1);
    assign rd_addr = top_dec[AW-1:0];
    assign wr_addr = top_reg[AW-1:0];

    // Pending stack: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE && !final_reg) begin
            mem[wr_addr] <= '{c1: pbc, c2: pc, e: p3_reg, level: level_reg + LW'(1)};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Datapath accumulators; act on the registered product, not the one being issued
    always_ff @(posedge aclk) begin
        prod_reg <= prod_c;
        if (state_reg == ST_TEST) begin
            case (step_reg)
                4'd1:  t_reg  <= prod_reg;
                4'd2:  cr_reg <= t_reg - prod_reg;
                4'd3:  begin
                    t_reg <= prod_reg;
                    d_reg <= cr_neg ? DW'(0) - cr_reg[DW-1:0] : cr_reg[DW-1:0];
                end
                4'd4:  cr_reg <= t_reg - prod_reg;
                4'd5:  begin
                    s_reg <= prod_u[DW-1:0];
                    d_reg <= cr_neg ? d_reg - cr_reg[DW-1:0] : d_reg + cr_reg[DW-1:0];
                end
                4'd6:  s_reg <= s_reg + prod_u[DW-1:0];
                4'd7:  q_reg <= QW'(prod_u[DW-1:0]);
                4'd8:  q_reg <= q_reg + (QW'(prod_u[DW-1:0]) << (H + 1));
                4'd9:  q_reg <= q_reg + (QW'(prod_u[DW-1:0]) << DW);
                4'd10: r_reg <= RW'(prod_u);
                4'd11: r_reg <= r_reg + (RW'(prod_u) << H);
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            top_reg     <= '0;
            n_reg       <= '0;
            level_reg   <= '0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            tol_reg     <= TOL_RESET;
            p0_reg      <= '0;
            p1_reg      <= '0;
            p2_reg      <= '0;
            p3_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            // raise on a new vertex, drop once the held one transfers
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        p0_reg      <= '{x: s_data.start_x, y: s_data.start_y};
                        p1_reg      <= '{x: s_data.ctrl1_x, y: s_data.ctrl1_y};
                        p2_reg      <= '{x: s_data.ctrl2_x, y: s_data.ctrl2_y};
                        p3_reg      <= '{x: s_data.end_x,   y: s_data.end_y};
                        seg_end_reg <= '{x: s_data.end_x,   y: s_data.end_y};
                        level_reg   <= '0;
                        top_reg     <= '0;
                        n_reg       <= '0;
                        step_reg    <= '0;
                        state_reg   <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    if (lim) begin
                        final_reg <= 1'b1;
                        state_reg <= ST_DECIDE;
                    end else if (step_reg == STEP_LAST) begin
                        final_reg <= flat_c;
                        state_reg <= ST_DECIDE;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_DECIDE: begin
                    if (!final_reg) begin
                        // keep the left half, push the right half
                        p1_reg    <= pa;
                        p2_reg    <= pab;
                        p3_reg    <= pm;
                        level_reg <= level_reg + LW'(1);
                        top_reg   <= top_reg + TW'(1);
                        step_reg  <= '0;
                        state_reg <= ST_TEST;
                    end else if (slot_free) begin
                        if (top_reg == '0) begin
                            out_reg   <= '{point_x: p3_reg.x, point_y: p3_reg.y,
                                           last_point: 1'b1};
                            state_reg <= ST_IDLE;
                        end else if (n_reg == NW'(MAX_POINTS - 1)) begin
                            // budget spent: close with the segment end, drop the rest
                            out_reg   <= '{point_x: seg_end_reg.x, point_y: seg_end_reg.y,
                                           last_point: 1'b1};
                            top_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            out_reg   <= '{point_x: p3_reg.x, point_y: p3_reg.y,
                                           last_point: 1'b0};
                            n_reg     <= n_reg + NW'(1);
                            top_reg   <= top_dec;
                            p0_reg    <= p3_reg;
                            state_reg <= ST_POP;
                        end
                    end
                end
                ST_POP: begin
                    p1_reg    <= rd_data_reg.c1;
                    p2_reg    <= rd_data_reg.c2;
                    p3_reg    <= rd_data_reg.e;
                    level_reg <= rd_data_reg.level;
                    step_reg  <= '0;
                    state_reg <= ST_TEST;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/cbf_checker.sv =====
module cbf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input cbf_pkg::cbf_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input cbf_pkg::cbf_out_t m_data
);
    import cbf_pkg::*;

    // a stalled vertex holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("vertex changed while stalled");

    // one segment at a time
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("segment taken while busy");

    // a pending non-final vertex means the segment is still open
    a_open_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_point |-> !s_ready)
        else $error("new segment taken before last vertex");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("vertex valid after reset");

endmodule

bind cubic_bezier_flattener cbf_checker u_cbf_checker (.*);
